// File: hw/rtl/afpp_pkg.sv
// shared types and constants of the advancing front point proposer
package afpp_pkg;

  // multiply-accumulate datapath widths
  localparam int OPW   = 35;          // signed operand width
  localparam int CHUNK = 17;          // low part of the b operand
  localparam int CHW   = OPW - CHUNK; // signed chunk width
  localparam int ACCW  = 70;          // accumulator width

  // sqrt(3)/2 in Q1.29 and ceil(2^38/100) for the nudge
  localparam logic signed [OPW-1:0] SQRT3_HALF = 35'sd464943848;
  localparam logic signed [OPW-1:0] RECIP_100  = 35'sd2748779070;
  localparam int APEX_SHIFT  = 29;
  localparam int RECIP_SHIFT = 38;
  localparam int NUDGE_W     = 25;

  // request kinds
  localparam logic [1:0] KIND_FRONT   = 2'd0;
  localparam logic [1:0] KIND_MESH    = 2'd1;
  localparam logic [1:0] KIND_PROPOSE = 2'd2;

  // register index
  localparam logic REG_SPACING = 1'b0;
  localparam logic [30:0] SPACING_RESET = 31'd6554;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_APEX  = 8'b0000_0010,
    S_FDIST = 8'b0000_0100,
    S_FCMP  = 8'b0000_1000,
    S_MSET  = 8'b0001_0000,
    S_MMAC  = 8'b0010_0000,
    S_MCAP  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic en;
    logic clr;
    logic hi;
    logic sub;
  } mac_ctrl_t;

endpackage

// File: hw/rtl/afpp_ram.sv
// generic single write, single read ram with registered read data
module afpp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/afpp_mac.sv
// shared multiply-accumulate unit, one 35x18 partial product per cycle while enabled
module afpp_mac (
  input  logic                                clk_i,
  input  afpp_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [afpp_pkg::OPW-1:0]     a_i,
  input  logic signed [afpp_pkg::OPW-1:0]     b_i,
  input  logic signed [afpp_pkg::ACCW-1:0]    base_i,
  output logic signed [afpp_pkg::ACCW-1:0]    acc_o
);
  import afpp_pkg::*;

  logic signed [CHW-1:0]      chunk;
  logic signed [OPW+CHW-1:0]  prod;
  logic signed [ACCW-1:0]     prod_ext;
  logic signed [ACCW-1:0]     term;
  logic signed [ACCW-1:0]     start;
  logic signed [ACCW-1:0]     acc_q;
  logic signed [ACCW-1:0]     acc_d;

  always_comb begin
    if (ctrl_i.hi) begin
      chunk = b_i[OPW-1:CHUNK];
    end else begin
      chunk = $signed({1'b0, b_i[CHUNK-1:0]});
    end
    prod     = a_i * chunk;
    prod_ext = ACCW'(prod);
    term     = ctrl_i.hi ? (prod_ext <<< CHUNK) : prod_ext;
    start    = ctrl_i.clr ? base_i : acc_q;
    acc_d    = ctrl_i.sub ? (start - term) : (start + term);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: hw/rtl/advancing_front_point_proposer_unit.sv
// top level of the advancing front point proposer: stores, sequencer and output register
//
// A front-point or mesh-segment load request is dropped when its store is full. A
// propose request builds the equilateral apex on edge b-c, scans every stored front point
// for the nearest one strictly inside spacing/1.5 (earliest wins ties), and, when a
// neighbor exists, tests both new edges against the mesh segments from the newest down,
// stopping at the first hit. Every product goes through one shared multiply-accumulate
// unit in two partial-product passes, the apex and radius setup included, and the segment
// tests exit early on x-range misses, double verticals and parallel lines. The input is
// not ready while a propose request runs; a finished result sits in an output register
// so the next request can be taken while it waits. The stores are plain rams with no
// clearing pass.
module advancing_front_point_proposer_unit #(
  parameter int FRONT_DEPTH = 256,
  parameter int MESH_DEPTH  = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input requests
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // x_start, y_start, x_end, y_end
  input  logic [1:0]   s_axis_tuser,   // kind
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // point_x, point_y, neighbor_index
  output logic [1:0]   m_axis_tuser,   // neighbor_found, rejected
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import afpp_pkg::*;

  localparam int FIW = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
  localparam int MIW = (MESH_DEPTH > 1) ? $clog2(MESH_DEPTH) : 1;
  localparam int FCW = FIW + 1;
  localparam int MCW = MIW + 1;

  // configuration register
  logic [30:0] spacing_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SPACING);
  assign prdata = (paddr[2] == REG_SPACING) ? {1'b0, spacing_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACING_RESET;
    end else if (cfg_we) begin
      spacing_q <= pwdata[30:0];
    end
  end

  // input fields
  logic        in_acc;
  logic [1:0]  in_kind;
  logic signed [31:0] in_xs, in_ys, in_xe, in_ye;

  assign in_kind = s_axis_tuser;
  assign in_xs   = s_axis_tdata[31:0];
  assign in_ys   = s_axis_tdata[63:32];
  assign in_xe   = s_axis_tdata[95:64];
  assign in_ye   = s_axis_tdata[127:96];

  // sequencer state
  state_e state_q, state_d;
  logic [3:0] ph_q, ph_d;
  logic [1:0] step_q, step_d;
  logic [1:0] pc_q, pc_d;
  logic       edge_q, edge_d;
  logic [FCW-1:0] front_cnt_q, front_cnt_d;
  logic [MCW-1:0] mesh_cnt_q, mesh_cnt_d;
  logic [FIW-1:0] fidx_q, fidx_d;
  logic [MIW-1:0] midx_q, midx_d;

  // proposal payload
  logic signed [31:0] bx_q, by_q, cx_q, cy_q;
  logic signed [31:0] ax_q, ax_d, ay_q, ay_d;
  logic [63:0]        s4_q, s4_d;
  logic [NUDGE_W-1:0] nudge_q, nudge_d;
  logic               found_q, found_d;
  logic [FIW-1:0]     best_q, best_d;
  logic [63:0]        bestd_q, bestd_d;
  logic signed [31:0] bestx_q, bestx_d, besty_q, besty_d;
  logic               rej_q, rej_d;
  logic signed [OPW-1:0] ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;
  logic signed [OPW-1:0] ux_d, uy_d, vx_d, vy_d, wx_d, wy_d;
  logic signed [ACCW-1:0] den_q, den_d;
  logic               tn_ok_q, tn_ok_d;

  // output register
  logic               m_valid_q, m_valid_d;
  logic signed [31:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic               out_found_q, out_found_d, out_rej_q, out_rej_d;
  logic [7:0]         out_idx_q, out_idx_d;
  logic [FIW+7:0]     best_ext;

  // rams
  logic           f_we, f_re, m_we, m_re;
  logic [FIW-1:0] f_raddr;
  logic [MIW-1:0] m_raddr;
  logic [63:0]    f_rdata;
  logic [127:0]   m_rdata;

  // mac
  mac_ctrl_t              mac_ctrl;
  logic signed [OPW-1:0]  mac_a, mac_b;
  logic signed [ACCW-1:0] mac_base, acc;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign f_we = in_acc && (in_kind == KIND_FRONT) && (front_cnt_q != FCW'(FRONT_DEPTH));
  assign m_we = in_acc && (in_kind == KIND_MESH) && (mesh_cnt_q != MCW'(MESH_DEPTH));

  afpp_ram #(.WIDTH(64), .DEPTH(FRONT_DEPTH)) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (front_cnt_q[FIW-1:0]),
    .wdata_i ({in_ys, in_xs}),
    .re_i    (f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  afpp_ram #(.WIDTH(128), .DEPTH(MESH_DEPTH)) u_mesh_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (mesh_cnt_q[MIW-1:0]),
    .wdata_i ({in_ye, in_xe, in_ys, in_xs}),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  afpp_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .base_i (mac_base),
    .acc_o  (acc)
  );

  // floor shift of the apex sum to q16.16 with saturation
  function automatic logic signed [31:0] apex_sat(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] t;
    t = v >>> APEX_SHIFT;
    if ((&t[ACCW-1:31]) || !(|t[ACCW-1:31])) begin
      apex_sat = t[31:0];
    end else if (t[ACCW-1]) begin
      apex_sat = 32'sh8000_0000;
    end else begin
      apex_sat = 32'sh7fff_ffff;
    end
  endfunction

  // value lies between zero and den, bounds included, den nonzero
  function automatic logic in_span(input logic signed [ACCW-1:0] t,
                                   input logic signed [ACCW-1:0] d);
    if (!d[ACCW-1]) begin
      in_span = !t[ACCW-1] && (t <= d);
    end else begin
      in_span = (t[ACCW-1] || (t == '0)) && (t >= d);
    end
  endfunction

  // front point distance terms
  logic signed [31:0] px, py;
  logic signed [32:0] dx, dy;
  logic               d_far, d_qual;
  logic [67:0]        d2x9;

  assign px = f_rdata[31:0];
  assign py = f_rdata[63:32];
  assign dx = 33'(px) - 33'(ax_q);
  assign dy = 33'(py) - 33'(ay_q);
  assign d_far = (dx[32] != dx[31]) || (dx == 33'sh1_8000_0000) ||
                 (dy[32] != dy[31]) || (dy == 33'sh1_8000_0000);
  assign d2x9 = {1'b0, acc[63:0], 3'b000} + {4'b0000, acc[63:0]};
  assign d_qual = !d_far && (d2x9 < {4'b0000, s4_q}) &&
                  (!found_q || (acc[63:0] < bestd_q));

  // segment setup terms
  logic signed [31:0] sx1, sy1, sx2, sy2, ex, ey, amax, pmin;
  logic signed [32:0] x1n, x3n;
  logic               p_vert, e_vert, early_miss;

  assign sx1 = m_rdata[31:0];
  assign sy1 = m_rdata[63:32];
  assign sx2 = m_rdata[95:64];
  assign sy2 = m_rdata[127:96];
  assign ex  = edge_q ? cx_q : bx_q;
  assign ey  = edge_q ? cy_q : by_q;
  assign amax = (ax_q > ex) ? ax_q : ex;
  assign pmin = (sx1 < sx2) ? sx1 : sx2;
  assign p_vert = (sx1 == sx2);
  assign e_vert = (ax_q == ex);
  assign early_miss = (amax < pmin) || (p_vert && e_vert);
  assign x3n = 33'(sx1) + (p_vert ? 33'(nudge_q) : 33'sd0);
  assign x1n = 33'(ax_q) + ((!p_vert && e_vert) ? 33'(nudge_q) : 33'sd0);

  assign best_ext = {8'd0, best_q};

  always_comb begin
    logic last_edge;
    logic signed [32:0] sum_t;

    state_d = state_q;
    ph_d = ph_q;
    step_d = step_q;
    pc_d = pc_q;
    edge_d = edge_q;
    front_cnt_d = front_cnt_q;
    mesh_cnt_d = mesh_cnt_q;
    fidx_d = fidx_q;
    midx_d = midx_q;
    ax_d = ax_q;
    ay_d = ay_q;
    s4_d = s4_q;
    nudge_d = nudge_q;
    found_d = found_q;
    best_d = best_q;
    bestd_d = bestd_q;
    bestx_d = bestx_q;
    besty_d = besty_q;
    rej_d = rej_q;
    ux_d = ux_q; uy_d = uy_q; vx_d = vx_q; vy_d = vy_q; wx_d = wx_q; wy_d = wy_q;
    den_d = den_q;
    tn_ok_d = tn_ok_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    out_x_d = out_x_q;
    out_y_d = out_y_q;
    out_found_d = out_found_q;
    out_rej_d = out_rej_q;
    out_idx_d = out_idx_q;
    f_re = 1'b0;
    f_raddr = fidx_q;
    m_re = 1'b0;
    m_raddr = midx_q;
    mac_ctrl = '0;
    mac_a = '0;
    mac_b = '0;
    mac_base = '0;
    last_edge = 1'b0;
    sum_t = '0;

    if (f_we) begin
      front_cnt_d = front_cnt_q + FCW'(1);
    end
    if (m_we) begin
      mesh_cnt_d = mesh_cnt_q + MCW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_PROPOSE)) begin
          state_d = S_APEX;
          ph_d = 4'd0;
          found_d = 1'b0;
          best_d = '0;
          rej_d = 1'b0;
        end
      end

      // apex x, apex y, 4*spacing^2 and the nudge, two passes each
      S_APEX: begin
        mac_ctrl.en  = (ph_q != 4'd8);
        mac_ctrl.hi  = ph_q[0];
        mac_ctrl.clr = !ph_q[0];
        case (ph_q[3:1])
          3'd0: begin
            sum_t = 33'(bx_q) + 33'(cx_q);
            mac_a = OPW'(33'(cy_q) - 33'(by_q));
            mac_b = SQRT3_HALF;
            mac_base = (ACCW'(sum_t) <<< (APEX_SHIFT - 1)) +
                       (ACCW'(1) <<< (APEX_SHIFT - 1));
          end
          3'd1: begin
            sum_t = 33'(by_q) + 33'(cy_q);
            mac_a = OPW'(33'(bx_q) - 33'(cx_q));
            mac_b = SQRT3_HALF;
            mac_base = (ACCW'(sum_t) <<< (APEX_SHIFT - 1)) +
                       (ACCW'(1) <<< (APEX_SHIFT - 1));
          end
          3'd2: begin
            mac_a = $signed(OPW'(spacing_q));
            mac_b = $signed(OPW'(spacing_q));
          end
          default: begin
            mac_a = $signed(OPW'(spacing_q));
            mac_b = RECIP_100;
          end
        endcase
        ph_d = ph_q + 4'd1;
        case (ph_q)
          4'd2: ax_d = apex_sat(acc);
          4'd4: ay_d = apex_sat(acc);
          4'd6: s4_d = {acc[61:0], 2'b00};
          4'd8: begin
            nudge_d = (acc[RECIP_SHIFT+NUDGE_W-1:RECIP_SHIFT] == '0) ?
                      NUDGE_W'(1) : acc[RECIP_SHIFT+NUDGE_W-1:RECIP_SHIFT];
            if (front_cnt_q == '0) begin
              state_d = S_DONE;
            end else begin
              fidx_d = '0;
              f_re = 1'b1;
              f_raddr = '0;
              step_d = 2'd0;
              state_d = S_FDIST;
            end
          end
          default: ;
        endcase
      end

      // dx^2 + dy^2 over four passes
      S_FDIST: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.hi  = step_q[0];
        mac_ctrl.clr = (step_q == 2'd0);
        mac_a = step_q[1] ? OPW'(dy) : OPW'(dx);
        mac_b = mac_a;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = S_FCMP;
        end
      end

      S_FCMP: begin
        if (d_qual) begin
          found_d = 1'b1;
          best_d = fidx_q;
          bestd_d = acc[63:0];
          bestx_d = px;
          besty_d = py;
        end
        if ((FCW'(fidx_q) + FCW'(1)) == front_cnt_q) begin
          if ((found_q || d_qual) && (mesh_cnt_q != '0)) begin
            midx_d = MIW'(mesh_cnt_q - MCW'(1));
            m_re = 1'b1;
            m_raddr = MIW'(mesh_cnt_q - MCW'(1));
            edge_d = 1'b0;
            state_d = S_MSET;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          fidx_d = fidx_q + FIW'(1);
          f_re = 1'b1;
          f_raddr = fidx_q + FIW'(1);
          step_d = 2'd0;
          state_d = S_FDIST;
        end
      end

      // edge vectors with the nudged copies
      S_MSET: begin
        if (early_miss) begin
          last_edge = 1'b1;
        end else begin
          ux_d = OPW'(33'(ex) - x1n);
          uy_d = OPW'(33'(ey) - 33'(ay_q));
          vx_d = OPW'(33'(sx2) - x3n);
          vy_d = OPW'(33'(sy2) - 33'(sy1));
          wx_d = OPW'(x3n - x1n);
          wy_d = OPW'(33'(sy1) - 33'(ay_q));
          pc_d = 2'd0;
          step_d = 2'd0;
          state_d = S_MMAC;
        end
      end

      // den, then t numerator, then u numerator
      S_MMAC: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.hi  = step_q[0];
        mac_ctrl.sub = step_q[1];
        mac_ctrl.clr = (step_q == 2'd0);
        case (pc_q)
          2'd0: begin
            mac_a = step_q[1] ? uy_q : ux_q;
            mac_b = step_q[1] ? vx_q : vy_q;
          end
          2'd1: begin
            mac_a = step_q[1] ? wy_q : wx_q;
            mac_b = step_q[1] ? vx_q : vy_q;
          end
          default: begin
            mac_a = step_q[1] ? wy_q : wx_q;
            mac_b = step_q[1] ? ux_q : uy_q;
          end
        endcase
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = S_MCAP;
        end
      end

      S_MCAP: begin
        case (pc_q)
          2'd0: begin
            den_d = acc;
            if (acc == '0) begin
              last_edge = 1'b1;
            end else begin
              pc_d = 2'd1;
              state_d = S_MMAC;
            end
          end
          2'd1: begin
            tn_ok_d = in_span(acc, den_q);
            pc_d = 2'd2;
            state_d = S_MMAC;
          end
          default: begin
            if (tn_ok_q && in_span(acc, den_q)) begin
              rej_d = 1'b1;
              state_d = S_DONE;
            end else begin
              last_edge = 1'b1;
            end
          end
        endcase
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_found_d = found_q;
          out_rej_d = rej_q;
          out_idx_d = found_q ? best_ext[7:0] : 8'd0;
          if (rej_q) begin
            out_x_d = '0;
            out_y_d = '0;
          end else if (found_q) begin
            out_x_d = bestx_q;
            out_y_d = besty_q;
          end else begin
            out_x_d = ax_q;
            out_y_d = ay_q;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // no hit on this edge: other edge, then the next older segment
    if (last_edge) begin
      if (!edge_q) begin
        edge_d = 1'b1;
        state_d = S_MSET;
      end else if (midx_q == '0) begin
        state_d = S_DONE;
      end else begin
        midx_d = midx_q - MIW'(1);
        m_re = 1'b1;
        m_raddr = midx_q - MIW'(1);
        edge_d = 1'b0;
        state_d = S_MSET;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q <= '0;
      step_q <= '0;
      pc_q <= '0;
      edge_q <= 1'b0;
      front_cnt_q <= '0;
      mesh_cnt_q <= '0;
      fidx_q <= '0;
      midx_q <= '0;
      found_q <= 1'b0;
      rej_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      step_q <= step_d;
      pc_q <= pc_d;
      edge_q <= edge_d;
      front_cnt_q <= front_cnt_d;
      mesh_cnt_q <= mesh_cnt_d;
      fidx_q <= fidx_d;
      midx_q <= midx_d;
      found_q <= found_d;
      rej_q <= rej_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bx_q <= in_xs;
      by_q <= in_ys;
      cx_q <= in_xe;
      cy_q <= in_ye;
    end
    ax_q <= ax_d;
    ay_q <= ay_d;
    s4_q <= s4_d;
    nudge_q <= nudge_d;
    best_q <= best_d;
    bestd_q <= bestd_d;
    bestx_q <= bestx_d;
    besty_q <= besty_d;
    ux_q <= ux_d; uy_q <= uy_d; vx_q <= vx_d; vy_q <= vy_d; wx_q <= wx_d; wy_q <= wy_d;
    den_q <= den_d;
    tn_ok_q <= tn_ok_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
    out_found_q <= out_found_d;
    out_rej_q <= out_rej_d;
    out_idx_q <= out_idx_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_idx_q, out_y_q, out_x_q};
  assign m_axis_tuser  = {out_rej_q, out_found_q};

endmodule
